### rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg - shared types and constants for the button press classifier
// Register indexes, event codes, widths and the structs passed between the
// top level and the classification core.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE   = 3'd0,
        REG_LONG_PRESS = 3'd1,
        REG_SETTLE     = 3'd2,
        REG_POLL       = 3'd3,
        REG_SHORT_MASK = 3'd4,
        REG_LONG_MASK  = 3'd5
    } t_reg_idx;

    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_BOOT_SHORT = 3'd1,
        EV_BOOT_LONG  = 3'd2,
        EV_PWR_SHORT  = 3'd3,
        EV_PWR_LONG   = 3'd4
    } t_event;

    localparam logic [9:0]  DEBOUNCE_RST   = 10'd50;
    localparam logic [13:0] LONG_PRESS_RST = 14'd1000;
    localparam logic [15:0] SETTLE_RST     = 16'd1500;
    localparam logic [9:0]  POLL_RST       = 10'd50;
    localparam logic [7:0]  SHORT_MASK_RST = 8'd8;
    localparam logic [7:0]  LONG_MASK_RST  = 8'd4;

    typedef struct packed {
        logic [9:0]  debounce_ms;
        logic [13:0] long_press_ms;
        logic [15:0] settle_ms;
        logic [9:0]  poll_ms;
        logic [7:0]  short_key_mask;
        logic [7:0]  long_key_mask;
    } t_cfg;

    typedef struct packed {
        t_event     event_res;
        logic [7:0] clear_mask;
    } t_result;

endpackage

### rtl/button_press_classifier.sv
// ----------------------------------------------------------------------------
// button_press_classifier - boot button and power key event classifier
// Top level: configuration registers, classification core and a two-entry
// result buffer.
// ----------------------------------------------------------------------------
// One input transfer is one millisecond tick and gives exactly one result
// transfer. A tick is taken in every clock cycle while the skid entry is empty;
// its result is registered. The result side has a two-entry buffer (output
// register plus skid entry), so a tick is still taken while one result waits
// to be collected; o_in_ready drops only when both entries are full. During
// the startup settle window each result is "no event" with a clear mask of
// both power key bits. Afterwards boot short/long presses and sampled power
// key presses are reported, at most one per tick, boot events first.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data and should
// only be changed while no results are pending.
// ----------------------------------------------------------------------------
module button_press_classifier (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bpc_pkg::CFG_W-1:0]     i_cfg_data,
    // tick input
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_boot_pressed,
    input  logic                          i_key_status_ok,
    input  logic [7:0]                    i_key_status,
    // result output
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [2:0]                    o_event_res,
    output logic [7:0]                    o_clear_mask
);
    import bpc_pkg::*;

    t_cfg    r_cfg;
    t_result core_result;
    t_result r_out, r_skid;
    logic    r_out_vld, r_skid_vld;
    logic    take;
    logic    pop;

    assign o_in_ready = !r_skid_vld;
    assign take       = i_in_valid && o_in_ready;
    assign pop        = r_out_vld && i_out_ready;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms    <= DEBOUNCE_RST;
            r_cfg.long_press_ms  <= LONG_PRESS_RST;
            r_cfg.settle_ms      <= SETTLE_RST;
            r_cfg.poll_ms        <= POLL_RST;
            r_cfg.short_key_mask <= SHORT_MASK_RST;
            r_cfg.long_key_mask  <= LONG_MASK_RST;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_DEBOUNCE:   r_cfg.debounce_ms    <= i_cfg_data[9:0];
                REG_LONG_PRESS: r_cfg.long_press_ms  <= i_cfg_data[13:0];
                REG_SETTLE:     r_cfg.settle_ms      <= i_cfg_data[15:0];
                REG_POLL:       r_cfg.poll_ms        <= i_cfg_data[9:0];
                REG_SHORT_MASK: r_cfg.short_key_mask <= i_cfg_data[7:0];
                REG_LONG_MASK:  r_cfg.long_key_mask  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    bpc_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_take          (take),
        .i_boot_pressed  (i_boot_pressed),
        .i_key_status_ok (i_key_status_ok),
        .i_key_status    (i_key_status),
        .o_result        (core_result)
    );

    // Result buffer control: the skid entry fills only when the output
    // register is held; it drains into the output register on the next pop.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (r_skid_vld) begin
                if (pop) begin
                    r_out_vld  <= 1'b1;
                    r_skid_vld <= 1'b0;
                end
            end else if (r_out_vld && !pop) begin
                r_skid_vld <= take;
            end else begin
                r_out_vld <= take;
            end
        end
    end

    // Payload, no reset needed.
    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (r_out_vld && !pop) begin
            if (take) begin
                r_skid <= core_result;
            end
        end else if (take) begin
            r_out <= core_result;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_event_res  = r_out.event_res;
    assign o_clear_mask = r_out.clear_mask;

endmodule

### rtl/bpc_core.sv
// ----------------------------------------------------------------------------
// bpc_core - tick state and per-tick classification
// Holds the tick counter and the boot/poll timing state; works out the result
// of the tick presented on the inputs and updates state when it is taken.
// ----------------------------------------------------------------------------
module bpc_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bpc_pkg::t_cfg    i_cfg,
    input  logic             i_take,
    input  logic             i_boot_pressed,
    input  logic             i_key_status_ok,
    input  logic [7:0]       i_key_status,
    output bpc_pkg::t_result o_result
);
    import bpc_pkg::*;

    logic [TIME_W-1:0] r_tick,      n_tick;
    logic              r_settled,   n_settled;
    logic              r_boot_down, n_boot_down;
    logic [TIME_W-1:0] r_edge_time, n_edge_time;
    logic              r_long_fired, n_long_fired;
    logic [TIME_W-1:0] r_poll_time, n_poll_time;

    logic [TIME_W-1:0] edge_age;
    logic [TIME_W-1:0] poll_age;
    logic [7:0]        both_mask;
    logic [7:0]        hit_mask;
    logic              in_settle;
    logic              edge_ok;
    logic              long_due;
    logic              poll_due;

    assign edge_age  = r_tick - r_edge_time;
    assign poll_age  = r_tick - r_poll_time;
    assign both_mask = i_cfg.short_key_mask | i_cfg.long_key_mask;
    assign hit_mask  = i_key_status & both_mask;
    assign in_settle = !r_settled && (r_tick < {{(TIME_W-16){1'b0}}, i_cfg.settle_ms});
    assign edge_ok   = (i_boot_pressed != r_boot_down) &&
                       (edge_age > {{(TIME_W-10){1'b0}}, i_cfg.debounce_ms});
    assign poll_due  = poll_age >= {{(TIME_W-10){1'b0}}, i_cfg.poll_ms};

    // A freshly accepted press has zero age, so only a zero hold time fires.
    always_comb begin
        if (edge_ok) begin
            long_due = (i_cfg.long_press_ms == '0);
        end else begin
            long_due = edge_age >= {{(TIME_W-14){1'b0}}, i_cfg.long_press_ms};
        end
    end

    always_comb begin
        n_tick       = r_tick + TIME_W'(1);
        n_settled    = r_settled;
        n_boot_down  = r_boot_down;
        n_edge_time  = r_edge_time;
        n_long_fired = r_long_fired;
        n_poll_time  = r_poll_time;
        o_result.event_res  = EV_NONE;
        o_result.clear_mask = '0;
        if (in_settle) begin
            o_result.clear_mask = both_mask;
        end else begin
            n_settled = 1'b1;
            if (edge_ok) begin
                n_boot_down = i_boot_pressed;
                n_edge_time = r_tick;
                if (i_boot_pressed) begin
                    n_long_fired = 1'b0;
                end
            end
            if (edge_ok && !i_boot_pressed && !r_long_fired) begin
                o_result.event_res = EV_BOOT_SHORT;
            end else if (n_boot_down && !n_long_fired && long_due) begin
                n_long_fired       = 1'b1;
                o_result.event_res = EV_BOOT_LONG;
            end else if (poll_due) begin
                n_poll_time = r_tick;
                if (i_key_status_ok && (hit_mask != '0)) begin
                    o_result.clear_mask = hit_mask;
                    if ((i_key_status & i_cfg.long_key_mask) != '0) begin
                        o_result.event_res = EV_PWR_LONG;
                    end else begin
                        o_result.event_res = EV_PWR_SHORT;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick       <= '0;
            r_settled    <= 1'b0;
            r_boot_down  <= 1'b0;
            r_edge_time  <= '0;
            r_long_fired <= 1'b0;
            r_poll_time  <= '0;
        end else if (i_take) begin
            r_tick       <= n_tick;
            r_settled    <= n_settled;
            r_boot_down  <= n_boot_down;
            r_edge_time  <= n_edge_time;
            r_long_fired <= n_long_fired;
            r_poll_time  <= n_poll_time;
        end
    end

endmodule

### rtl/bpc_checker.sv
// ----------------------------------------------------------------------------
// bpc_checker - port-level checks for the button press classifier
// Watches the top level's ports and flags result transfers that break the
// event and clear mask rules.
// ----------------------------------------------------------------------------
module bpc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [2:0] o_event_res,
    input logic [7:0] o_clear_mask
);
    import bpc_pkg::*;

    // A held result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transfer");

    // Nothing is offered straight after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered after reset");

    // Boot events never request a status clear.
    a_boot_no_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_res == EV_BOOT_SHORT || o_event_res == EV_BOOT_LONG)
        |-> o_clear_mask == '0)
        else $error("boot event with clear mask");

    // Power events always carry the bits that caused them.
    a_pwr_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_res == EV_PWR_SHORT || o_event_res == EV_PWR_LONG)
        |-> o_clear_mask != '0)
        else $error("power event without clear mask");

    // A result can only appear if an input transfer took place earlier.
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready))
        else $error("result without input transfer");

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_event_res  (o_event_res),
    .o_clear_mask (o_clear_mask)
);
